// ----- rtl/lpm_pkg.sv -----
// ----------------------------------------------------------------------------
// lpm_pkg
// Types and constants shared by the prefix match router files.
// ----------------------------------------------------------------------------
package lpm_pkg;

    localparam int unsigned ADDR_W  = 32;
    localparam int unsigned LEN_W   = 6;
    localparam int unsigned IFACE_W = 4;
    localparam int unsigned TTL_W   = 8;
    localparam int unsigned STAT_W  = 3;

    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(ADDR_W);

    localparam logic CMD_ADD    = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    localparam logic [STAT_W-1:0] STAT_FORWARD  = 3'd0;
    localparam logic [STAT_W-1:0] STAT_NO_ROUTE = 3'd1;
    localparam logic [STAT_W-1:0] STAT_EXPIRED  = 3'd2;
    localparam logic [STAT_W-1:0] STAT_ADDED    = 3'd3;
    localparam logic [STAT_W-1:0] STAT_FULL     = 3'd4;

    typedef struct packed {
        logic                command;
        logic [ADDR_W-1:0]   route_prefix_in;
        logic [LEN_W-1:0]    prefix_len_in;
        logic                hop_present;
        logic [ADDR_W-1:0]   hop_addr_in;
        logic [IFACE_W-1:0]  iface_in;
        logic [ADDR_W-1:0]   dest_addr;
        logic [TTL_W-1:0]    ttl_in;
    } req_word_t;

    typedef struct packed {
        logic [STAT_W-1:0]   status;
        logic [IFACE_W-1:0]  iface_out;
        logic [ADDR_W-1:0]   hop_addr_out;
        logic [TTL_W-1:0]    ttl_out;
    } rsp_word_t;

    typedef struct packed {
        logic [ADDR_W-1:0]   prefix;
        logic [LEN_W-1:0]    len;
        logic                hop_flag;
        logic [ADDR_W-1:0]   hop;
        logic [IFACE_W-1:0]  iface;
    } route_t;

    typedef struct packed {
        logic                take;
        logic [LEN_W-1:0]    len;
        logic [IFACE_W-1:0]  iface;
        logic [ADDR_W-1:0]   hop;
    } match_t;

endpackage

// ----- rtl/lpm_chan_if.sv -----
// ----------------------------------------------------------------------------
// lpm_chan_if
// Valid/ready channel that moves one word per handshake.
// ----------------------------------------------------------------------------
interface lpm_chan_if #(
    parameter type word_t = logic
);
    logic  valid;
    logic  ready;
    word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/lpm_ram.sv -----
// ----------------------------------------------------------------------------
// lpm_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module lpm_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

// ----- rtl/lpm_match.sv -----
// ----------------------------------------------------------------------------
// lpm_match
// Compares one stored route with the destination and decides whether it
// replaces the best match found so far.
// ----------------------------------------------------------------------------
module lpm_match (
    input  lpm_pkg::route_t              entry,
    input  logic [lpm_pkg::ADDR_W-1:0]   dest,
    input  logic                         found,
    input  logic [lpm_pkg::LEN_W-1:0]    best_len,
    output lpm_pkg::match_t              result
);
    import lpm_pkg::*;

    logic [ADDR_W-1:0] mask;
    logic              hit;

    always_comb
    begin
        if (entry.len == '0)
        begin
            mask = '0;
        end
        else
        begin
            mask = {ADDR_W{1'b1}} << (MAX_LEN - entry.len);
        end
    end

    assign hit = (((dest ^ entry.prefix) & mask) == '0);

    assign result.take  = hit && (!found || (entry.len >= best_len));
    assign result.len   = entry.len;
    assign result.iface = entry.iface;
    assign result.hop   = entry.hop_flag ? entry.hop : dest;
endmodule

// ----- rtl/longest_prefix_match_router.sv -----
// ----------------------------------------------------------------------------
// longest_prefix_match_router
// IPv4 forwarding table with longest prefix match. An add word appends a
// route, or answers table full. A lookup word with a time to live above one
// scans the stored routes one per cycle through a single compare unit and
// keeps the longest match, the later route winning a tie. Each input word
// gives one result word. An add or an expired lookup goes from idle straight
// to the finish state; a lookup passes through the scan state first, its
// length set by the one read port of the route RAM that the scan walks
// through and its registered read. The block takes no new word while it
// works on one; a finished result waits in an output register so that the
// next word may be taken meanwhile.
// ----------------------------------------------------------------------------
module longest_prefix_match_router #(
    parameter int unsigned TABLE_DEPTH = 64
) (
    input  logic      clk,
    input  logic      rst_n,
    lpm_chan_if.sink   req,
    lpm_chan_if.source rsp
);
    import lpm_pkg::*;

    localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_DEPTH);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    logic [1:0]          state_reg,    state_next;
    logic [CW-1:0]       count_reg,    count_next;
    logic [CW-1:0]       scan_idx_reg, scan_idx_next;
    logic                pend_reg,     pend_next;
    logic                found_reg,    found_next;
    logic [LEN_W-1:0]    best_len_reg, best_len_next;
    logic [IFACE_W-1:0]  best_if_reg,  best_if_next;
    logic [ADDR_W-1:0]   best_hop_reg, best_hop_next;
    logic [ADDR_W-1:0]   dest_reg,     dest_next;
    logic [TTL_W-1:0]    ttl_reg,      ttl_next;
    logic [STAT_W-1:0]   status_reg,   status_next;
    logic                out_valid_reg, out_valid_next;
    rsp_word_t           out_data_reg,  out_data_next;

    logic                accept;
    logic                we;
    route_t              wentry;
    route_t              rentry;
    match_t              cand;

    assign accept = req.valid && req.ready;
    assign req.ready = (state_reg == ST_IDLE);

    always_comb
    begin
        wentry.prefix   = req.data.route_prefix_in;
        wentry.len      = (req.data.prefix_len_in > MAX_LEN) ? MAX_LEN
                                                            : req.data.prefix_len_in;
        wentry.hop_flag = req.data.hop_present;
        wentry.hop      = req.data.hop_addr_in;
        wentry.iface    = req.data.iface_in;
    end

    assign we = accept && (req.data.command == CMD_ADD) && (count_reg != FULL_COUNT);

    lpm_ram #(
        .WIDTH ($bits(route_t)),
        .DEPTH (TABLE_DEPTH)
    ) u_route_ram (
        .clk   (clk),
        .we    (we),
        .waddr (count_reg[AW-1:0]),
        .wdata (wentry),
        .raddr (scan_idx_reg[AW-1:0]),
        .rdata (rentry)
    );

    lpm_match u_match (
        .entry    (rentry),
        .dest     (dest_reg),
        .found    (found_reg),
        .best_len (best_len_reg),
        .result   (cand)
    );

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        scan_idx_next  = scan_idx_reg;
        pend_next      = 1'b0;
        found_next     = found_reg;
        best_len_next  = best_len_reg;
        best_if_next   = best_if_reg;
        best_hop_next  = best_hop_reg;
        dest_next      = dest_reg;
        ttl_next       = ttl_reg;
        status_next    = status_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    dest_next     = req.data.dest_addr;
                    ttl_next      = req.data.ttl_in;
                    found_next    = 1'b0;
                    best_len_next = '0;
                    scan_idx_next = '0;
                    state_next    = ST_FINISH;
                    if (req.data.command == CMD_ADD)
                    begin
                        if (count_reg == FULL_COUNT)
                        begin
                            status_next = STAT_FULL;
                        end
                        else
                        begin
                            status_next = STAT_ADDED;
                            count_next  = count_reg + 1'b1;
                        end
                    end
                    else if (req.data.ttl_in <= TTL_W'(1))
                    begin
                        status_next = STAT_EXPIRED;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (pend_reg && cand.take)
                begin
                    found_next    = 1'b1;
                    best_len_next = cand.len;
                    best_if_next  = cand.iface;
                    best_hop_next = cand.hop;
                end
                if (scan_idx_reg < count_reg)
                begin
                    pend_next     = 1'b1;
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
                else if (!pend_reg)
                begin
                    status_next = found_reg ? STAT_FORWARD : STAT_NO_ROUTE;
                    state_next  = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next.status = status_reg;
                    if (status_reg == STAT_FORWARD)
                    begin
                        out_data_next.iface_out    = best_if_reg;
                        out_data_next.hop_addr_out = best_hop_reg;
                        out_data_next.ttl_out      = ttl_reg - 1'b1;
                    end
                    else
                    begin
                        out_data_next.iface_out    = '0;
                        out_data_next.hop_addr_out = '0;
                        out_data_next.ttl_out      = '0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            scan_idx_reg  <= '0;
            pend_reg      <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            scan_idx_reg  <= scan_idx_next;
            pend_reg      <= pend_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_len_reg <= best_len_next;
        best_if_reg  <= best_if_next;
        best_hop_reg <= best_hop_next;
        dest_reg     <= dest_next;
        ttl_reg      <= ttl_next;
        status_reg   <= status_next;
        out_data_reg <= out_data_next;
    end

    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_data_reg;
endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench for the longest prefix match router. A directed burst checks
// the empty table, expired TTLs, direct routes, length saturation and equal
// length ties. Then random traffic fills the table with nested prefixes,
// runs into the table full case and looks up destinations taken from
// stored routes. Both channels idle and stall at random in two phases, and
// run back to back after a long response hold in the third. A forwarding
// table model predicts every result word and checks it field by field.
// ----------------------------------------------------------------------------
module tb;
    import lpm_pkg::*;

    localparam int unsigned TABLE_DEPTH  = 64;
    localparam int unsigned RANDOM_ITEMS = 830;
    localparam int unsigned LONG_HOLD    = 400;
    localparam int unsigned REPORT_LIMIT = 10;

    class forwarding_table_model;
        route_t      routes[TABLE_DEPTH];
        int unsigned route_count;
        rsp_word_t   pending_results[$];
        int unsigned failures;

        function new();
            route_count = 0;
            failures    = 0;
        endfunction

        function logic [ADDR_W-1:0] prefix_mask(logic [LEN_W-1:0] len);
            if (len == '0)
                return '0;
            return {ADDR_W{1'b1}} << (ADDR_W - len);
        endfunction

        function void note_request(req_word_t w);
            rsp_word_t         res;
            route_t            entry;
            logic [ADDR_W-1:0] m;
            logic              found;
            logic [LEN_W-1:0]  best_len;
            res      = '0;
            found    = 1'b0;
            best_len = '0;
            if (w.command == CMD_ADD) begin
                if (route_count >= TABLE_DEPTH) begin
                    res.status = STAT_FULL;
                end
                else begin
                    entry.prefix   = w.route_prefix_in;
                    entry.len      = (w.prefix_len_in > MAX_LEN) ? MAX_LEN : w.prefix_len_in;
                    entry.hop_flag = w.hop_present;
                    entry.hop      = w.hop_addr_in;
                    entry.iface    = w.iface_in;
                    routes[route_count] = entry;
                    route_count++;
                    res.status = STAT_ADDED;
                end
            end
            else if (w.ttl_in <= 8'd1) begin
                res.status = STAT_EXPIRED;
            end
            else begin
                for (int unsigned k = 0; k < route_count; k++) begin
                    m = prefix_mask(routes[k].len);
                    if ((w.dest_addr & m) == (routes[k].prefix & m) &&
                        (!found || routes[k].len >= best_len)) begin
                        found            = 1'b1;
                        best_len         = routes[k].len;
                        res.iface_out    = routes[k].iface;
                        res.hop_addr_out = routes[k].hop_flag ? routes[k].hop : w.dest_addr;
                    end
                end
                if (found) begin
                    res.status  = STAT_FORWARD;
                    res.ttl_out = w.ttl_in - 8'd1;
                end
                else begin
                    res.iface_out    = '0;
                    res.hop_addr_out = '0;
                    res.status       = STAT_NO_ROUTE;
                end
            end
            pending_results = {pending_results, res};
        endfunction

        function void check_result(rsp_word_t got);
            rsp_word_t want;
            if (pending_results.size() == 0) begin
                failures++;
                if (failures <= REPORT_LIMIT)
                    $display("unexpected word: status %0d iface %0d hop %h ttl %0d",
                             got.status, got.iface_out, got.hop_addr_out, got.ttl_out);
                return;
            end
            want = pending_results.pop_front();
            if (got.status !== want.status || got.iface_out !== want.iface_out ||
                got.hop_addr_out !== want.hop_addr_out || got.ttl_out !== want.ttl_out) begin
                failures++;
                if (failures <= REPORT_LIMIT)
                    $display({"mismatch: expected status %0d iface %0d hop %h ttl %0d, ",
                              "got status %0d iface %0d hop %h ttl %0d"},
                             want.status, want.iface_out, want.hop_addr_out, want.ttl_out,
                             got.status, got.iface_out, got.hop_addr_out, got.ttl_out);
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    lpm_chan_if #(.word_t(req_word_t)) req_ch ();
    lpm_chan_if #(.word_t(rsp_word_t)) rsp_ch ();

    forwarding_table_model model = new();

    int unsigned req_idle_pct;
    int unsigned rsp_idle_pct;
    bit          long_hold_req;

    longest_prefix_match_router #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) dut (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req_ch),
        .rsp  (rsp_ch)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic req_word_t add_word(logic [ADDR_W-1:0] prefix, logic [LEN_W-1:0] len,
                                           logic has_hop, logic [ADDR_W-1:0] hop,
                                           logic [IFACE_W-1:0] iface);
        req_word_t w;
        w.command         = CMD_ADD;
        w.route_prefix_in = prefix;
        w.prefix_len_in   = len;
        w.hop_present     = has_hop;
        w.hop_addr_in     = hop;
        w.iface_in        = iface;
        w.dest_addr       = $urandom;
        w.ttl_in          = TTL_W'($urandom);
        return w;
    endfunction

    function automatic req_word_t lookup(logic [ADDR_W-1:0] dest, logic [TTL_W-1:0] ttl);
        req_word_t w;
        w.command         = CMD_LOOKUP;
        w.route_prefix_in = $urandom;
        w.prefix_len_in   = LEN_W'($urandom);
        w.hop_present     = 1'($urandom);
        w.hop_addr_in     = $urandom;
        w.iface_in        = IFACE_W'($urandom);
        w.dest_addr       = dest;
        w.ttl_in          = ttl;
        return w;
    endfunction

    function automatic req_word_t random_item();
        logic [ADDR_W-1:0] addr;
        logic [ADDR_W-1:0] m;
        logic [LEN_W-1:0]  len;
        logic [TTL_W-1:0]  ttl;
        int unsigned       k;
        bit                derived;
        addr    = $urandom;
        derived = model.route_count != 0 && $urandom_range(99) < 70;
        k       = (model.route_count != 0) ? $urandom_range(model.route_count - 1) : 0;
        if (derived) begin
            m    = model.prefix_mask(model.routes[k].len);
            addr = (model.routes[k].prefix & m) | (addr & ~m);
        end
        if ($urandom_range(99) < 15) begin
            // The last free entry always gets the default route, so that
            // lookups without a matching route stay possible until then.
            if (model.route_count == TABLE_DEPTH - 1)
                len = '0;
            else if ($urandom_range(9) == 0)
                len = LEN_W'($urandom_range(63, 33));
            else if (derived && $urandom_range(3) == 0)
                len = model.routes[k].len;
            else
                len = LEN_W'($urandom_range(32, 1));
            return add_word(addr, len, 1'($urandom), $urandom, IFACE_W'($urandom));
        end
        ttl = ($urandom_range(9) == 0) ? TTL_W'($urandom_range(1))
                                       : TTL_W'($urandom_range(255, 2));
        return lookup(addr, ttl);
    endfunction

    task automatic send_word(input req_word_t w);
        while ($urandom_range(99) < req_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data  <= w;
        do
            @(posedge clk);
        while (!req_ch.ready);
        model.note_request(w);
    endtask

    task automatic pause_until_drained();
        req_ch.valid <= 1'b0;
        while (model.pending_results.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin : receiver
        int unsigned hold_left;
        hold_left    = 0;
        rsp_ch.ready = 1'b0;
        forever begin
            @(posedge clk);
            if (rsp_ch.valid && rsp_ch.ready)
                model.check_result(rsp_ch.data);
            if (long_hold_req) begin
                hold_left     = LONG_HOLD;
                long_hold_req = 1'b0;
            end
            if (hold_left != 0) begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else begin
                rsp_ch.ready <= ($urandom_range(99) >= rsp_idle_pct);
            end
        end
    end

    initial
    begin : stimulus
        rst_n         = 1'b0;
        req_ch.valid  = 1'b0;
        req_ch.data   = '0;
        long_hold_req = 1'b0;
        req_idle_pct  = 38;
        rsp_idle_pct  = 78;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        send_word(lookup(32'h0A01_0203, 8'd64));
        send_word(lookup(32'h0A01_0203, 8'd0));
        send_word(lookup(32'hFFFF_FFFF, 8'd1));
        send_word(add_word(32'h0A00_0000, 6'd8, 1'b0, 32'hDEAD_BEEF, 4'd1));
        send_word(lookup(32'h0A7F_0001, 8'd255));
        send_word(lookup(32'h0B00_0000, 8'd2));
        send_word(add_word(32'h0A01_0000, 6'd16, 1'b1, 32'hC0A8_0001, 4'd2));
        send_word(add_word(32'h0A01_FFFF, 6'd16, 1'b1, 32'hC0A8_0002, 4'd3));
        send_word(lookup(32'h0A01_0203, 8'd2));
        send_word(add_word(32'h0A01_0203, 6'd63, 1'b1, 32'hFFFF_FFFF, 4'd15));
        send_word(add_word(32'h0A01_0204, 6'd33, 1'b0, 32'h0000_0000, 4'd4));
        send_word(lookup(32'h0A01_0203, 8'd128));
        send_word(lookup(32'h0A01_0204, 8'd128));
        send_word(lookup(32'h0A01_0205, 8'd128));
        send_word(add_word(32'h8000_0000, 6'd1, 1'b1, 32'h0000_0000, 4'd0));
        send_word(lookup(32'hFFFF_FFFF, 8'd255));
        send_word(lookup(32'h7FFF_FFFF, 8'd255));
        send_word(add_word(32'h0000_0000, 6'd32, 1'b0, 32'hFFFF_FFFF, 4'd7));
        send_word(lookup(32'h0000_0000, 8'd3));
        send_word(lookup(32'h0A01_0203, 8'd1));
        send_word(lookup(32'h0A01_0203, 8'd0));

        for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS / 3) begin
                pause_until_drained();
                req_idle_pct = 78;
                rsp_idle_pct = 38;
            end
            else if (n == 2 * RANDOM_ITEMS / 3) begin
                pause_until_drained();
                req_idle_pct  = 0;
                rsp_idle_pct  = 0;
                long_hold_req = 1'b1;
            end
            send_word(random_item());
        end

        pause_until_drained();
        repeat (TABLE_DEPTH + 8) @(posedge clk);
        if (model.failures == 0 && model.pending_results.size() == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

    initial
    begin : watchdog
        #10_000_000;
        $display("tb: FAIL");
        $finish;
    end
endmodule
